// File: rtl/kpms_pkg.sv
// Shared widths, reset values, codes and types of the key press motion sequencer.
package kpms_pkg;

    localparam int NUM_KEYS_DEF   = 25;
    localparam int TIMER_BITS_DEF = 32;

    localparam int NOTE_W   = 5;
    localparam int DUR_W    = 8;
    localparam int POS_W    = 15;
    localparam int PULSE_W  = 16;
    localparam int HALF_W   = 16;
    localparam int SPACE_W  = 10;
    localparam int TICKS_W  = 24;
    localparam int PROD_W   = DUR_W + TICKS_W;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HALF_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SPACING       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_KEY_EXTRA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_UNIT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_DOWN_PULSE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_UP_PULSE   = 3'd6;

    // Register reset values
    localparam logic [HALF_W-1:0]  STEP_HALF_PERIOD_RST  = 16'd2000;
    localparam logic [SPACE_W-1:0] KEY_SPACING_RST       = 10'd150;
    localparam logic [SPACE_W-1:0] LAST_KEY_EXTRA_RST    = 10'd200;
    localparam logic [TICKS_W-1:0] HOLD_UNIT_RST         = 24'd5000000;
    localparam logic [TICKS_W-1:0] RELEASE_TIME_RST      = 24'd500000;
    localparam logic [PULSE_W-1:0] FINGER_DOWN_PULSE_RST = 16'd1000;
    localparam logic [PULSE_W-1:0] FINGER_UP_PULSE_RST   = 16'd2000;

    // Motion phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HIGH = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LOW  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REL  = 3'd4;

    typedef struct packed {
        logic [HALF_W-1:0]  step_half_period;
        logic [SPACE_W-1:0] key_spacing;
        logic [SPACE_W-1:0] last_key_extra;
        logic [TICKS_W-1:0] hold_unit;
        logic [TICKS_W-1:0] release_time;
        logic [PULSE_W-1:0] finger_down_pulse;
        logic [PULSE_W-1:0] finger_up_pulse;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [NOTE_W-1:0] note;
        logic [DUR_W-1:0]  duration;
    } item_t;

    typedef struct packed {
        logic               step_pin;
        logic               dir_pin;
        logic [PULSE_W-1:0] finger_pulse;
        logic               busy_res;
        logic               note_done;
        logic               rejected;
        logic [POS_W-1:0]   position;
    } result_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   position;
    } status_t;

endpackage

// File: rtl/kpms_ifs.sv
// Valid/ready channel interfaces for commands and results.
interface kpms_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [kpms_pkg::NOTE_W-1:0] note;
    logic [kpms_pkg::DUR_W-1:0]  duration;

    modport source (output valid, output kind, output note, output duration, input ready);
    modport sink (input valid, input kind, input note, input duration, output ready);
endinterface

interface kpms_res_if;
    logic                         valid;
    logic                         ready;
    logic                         step_pin;
    logic                         dir_pin;
    logic [kpms_pkg::PULSE_W-1:0] finger_pulse;
    logic                         busy_res;
    logic                         note_done;
    logic                         rejected;
    logic [kpms_pkg::POS_W-1:0]   position;

    modport source (output valid, output step_pin, output dir_pin, output finger_pulse,
                    output busy_res, output note_done, output rejected, output position,
                    input ready);
    modport sink (input valid, input step_pin, input dir_pin, input finger_pulse,
                  input busy_res, input note_done, input rejected, input position,
                  output ready);
endinterface

// File: rtl/kpms_cfg_regs.sv
// Configuration register file of the key press motion sequencer.
module kpms_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kpms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kpms_pkg::CFG_DATA_W-1:0]     cfg_data,
    output kpms_pkg::cfg_t                      cfg
);

    kpms_pkg::cfg_t cfg_reg;
    kpms_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                kpms_pkg::CFG_STEP_HALF_PERIOD:
                    cfg_next.step_half_period = cfg_data[kpms_pkg::HALF_W-1:0];
                kpms_pkg::CFG_KEY_SPACING:
                    cfg_next.key_spacing = cfg_data[kpms_pkg::SPACE_W-1:0];
                kpms_pkg::CFG_LAST_KEY_EXTRA:
                    cfg_next.last_key_extra = cfg_data[kpms_pkg::SPACE_W-1:0];
                kpms_pkg::CFG_HOLD_UNIT:
                    cfg_next.hold_unit = cfg_data[kpms_pkg::TICKS_W-1:0];
                kpms_pkg::CFG_RELEASE_TIME:
                    cfg_next.release_time = cfg_data[kpms_pkg::TICKS_W-1:0];
                kpms_pkg::CFG_FINGER_DOWN_PULSE:
                    cfg_next.finger_down_pulse = cfg_data[kpms_pkg::PULSE_W-1:0];
                kpms_pkg::CFG_FINGER_UP_PULSE:
                    cfg_next.finger_up_pulse = cfg_data[kpms_pkg::PULSE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_half_period  <= kpms_pkg::STEP_HALF_PERIOD_RST;
            cfg_reg.key_spacing       <= kpms_pkg::KEY_SPACING_RST;
            cfg_reg.last_key_extra    <= kpms_pkg::LAST_KEY_EXTRA_RST;
            cfg_reg.hold_unit         <= kpms_pkg::HOLD_UNIT_RST;
            cfg_reg.release_time      <= kpms_pkg::RELEASE_TIME_RST;
            cfg_reg.finger_down_pulse <= kpms_pkg::FINGER_DOWN_PULSE_RST;
            cfg_reg.finger_up_pulse   <= kpms_pkg::FINGER_UP_PULSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/kpms_engine.sv
// Motion state registers and the single-pass update for one tick or command.
module kpms_engine #(
    parameter int NUM_KEYS   = kpms_pkg::NUM_KEYS_DEF,
    parameter int TIMER_BITS = kpms_pkg::TIMER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  kpms_pkg::item_t      item,
    input  kpms_pkg::cfg_t       cfg,
    output kpms_pkg::result_t    res_next,
    output kpms_pkg::status_t    status
);

    localparam int EXT_W = (TIMER_BITS > kpms_pkg::PROD_W) ? TIMER_BITS : kpms_pkg::PROD_W;
    localparam logic [kpms_pkg::NOTE_W-1:0] LAST_KEY    = kpms_pkg::NOTE_W'(NUM_KEYS - 1);
    localparam logic [kpms_pkg::NOTE_W-1:0] SECOND_LAST = kpms_pkg::NOTE_W'(NUM_KEYS - 2);
    localparam logic [kpms_pkg::NOTE_W-1:0] KEY_COUNT   = kpms_pkg::NOTE_W'(NUM_KEYS);

    logic [kpms_pkg::PHASE_W-1:0] phase_reg,  phase_next;
    logic [kpms_pkg::POS_W-1:0]   pos_reg,    pos_next;
    logic [kpms_pkg::POS_W-1:0]   target_reg, target_next;
    logic [TIMER_BITS-1:0]        timer_reg,  timer_next;
    logic [kpms_pkg::DUR_W-1:0]   held_reg,   held_next;
    logic [kpms_pkg::PULSE_W-1:0] servo_reg,  servo_next;
    logic                         dir_reg,    dir_next;

    logic [kpms_pkg::NOTE_W-1:0]  key;
    logic                         is_last;
    logic [kpms_pkg::NOTE_W-1:0]  key_mul;
    logic [kpms_pkg::POS_W-1:0]   tgt_prod;
    logic [kpms_pkg::POS_W-1:0]   tgt_cmd;
    logic [kpms_pkg::POS_W-1:0]   tgt_src;
    logic                         note_ok;
    logic                         cmd_go;
    logic                         rej;
    logic [kpms_pkg::DUR_W-1:0]   dur_sel;
    logic [kpms_pkg::PROD_W-1:0]  hold_prod;
    logic [EXT_W-1:0]             hold_ext;
    logic [EXT_W-1:0]             tmax_ext;
    logic [EXT_W-1:0]             rel_ext;
    logic [TIMER_BITS-1:0]        hold_ticks;
    logic [TIMER_BITS-1:0]        rel_ticks;
    logic [TIMER_BITS-1:0]        half_ticks;
    logic [TIMER_BITS-1:0]        timer_dec;
    logic                         do_move;
    logic                         do_hold;
    logic                         do_release;
    logic                         done;

    // Target position of a new note; the last key sits an extra offset past the second-last
    assign key      = item.note - kpms_pkg::NOTE_W'(1);
    assign is_last  = (key == LAST_KEY);
    assign key_mul  = is_last ? SECOND_LAST : key;
    assign tgt_prod = kpms_pkg::POS_W'(key_mul) * kpms_pkg::POS_W'(cfg.key_spacing);
    assign tgt_cmd  = tgt_prod + (is_last ? kpms_pkg::POS_W'(cfg.last_key_extra)
                                          : kpms_pkg::POS_W'(0));
    assign tgt_src  = item.kind ? tgt_cmd : target_reg;

    assign note_ok = (item.note != '0) && (item.note <= KEY_COUNT);
    assign cmd_go  = item.kind && (phase_reg == kpms_pkg::PH_IDLE) && note_ok;
    assign rej     = item.kind && !((phase_reg == kpms_pkg::PH_IDLE) && note_ok);

    // Hold length, saturated to the timer width
    assign dur_sel    = item.kind ? item.duration : held_reg;
    assign hold_prod  = kpms_pkg::PROD_W'(dur_sel) * kpms_pkg::PROD_W'(cfg.hold_unit);
    assign hold_ext   = EXT_W'(hold_prod);
    assign tmax_ext   = EXT_W'({TIMER_BITS{1'b1}});
    assign hold_ticks = (hold_ext > tmax_ext) ? '1 : hold_ext[TIMER_BITS-1:0];
    assign rel_ext    = EXT_W'(cfg.release_time);
    assign rel_ticks  = rel_ext[TIMER_BITS-1:0];
    assign half_ticks = (cfg.step_half_period == '0) ? TIMER_BITS'(1)
                                                     : TIMER_BITS'(cfg.step_half_period);
    assign timer_dec  = (timer_reg != '0) ? (timer_reg - TIMER_BITS'(1)) : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        timer_next  = timer_reg;
        held_next   = held_reg;
        servo_next  = servo_reg;
        dir_next    = dir_reg;
        do_move     = 1'b0;
        do_hold     = 1'b0;
        do_release  = 1'b0;
        done        = 1'b0;

        if (cmd_go)
        begin
            target_next = tgt_cmd;
            held_next   = item.duration;
            do_move     = 1'b1;
        end
        else if (!item.kind && (phase_reg != kpms_pkg::PH_IDLE))
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                case (phase_reg)
                    kpms_pkg::PH_HIGH:
                    begin
                        phase_next = kpms_pkg::PH_LOW;
                        timer_next = half_ticks;
                    end
                    kpms_pkg::PH_LOW:
                        do_move = 1'b1;
                    kpms_pkg::PH_HOLD:
                        do_release = 1'b1;
                    default:
                    begin
                        phase_next = kpms_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end

        if (do_move)
        begin
            if (pos_reg == tgt_src)
            begin
                do_hold = 1'b1;
            end
            else
            begin
                if (tgt_src > pos_reg)
                begin
                    dir_next = 1'b0;
                    pos_next = pos_reg + kpms_pkg::POS_W'(1);
                end
                else
                begin
                    dir_next = 1'b1;
                    pos_next = pos_reg - kpms_pkg::POS_W'(1);
                end
                phase_next = kpms_pkg::PH_HIGH;
                timer_next = half_ticks;
            end
        end

        if (do_hold)
        begin
            servo_next = cfg.finger_down_pulse;
            timer_next = hold_ticks;
            if (hold_ticks == '0)
                do_release = 1'b1;
            else
                phase_next = kpms_pkg::PH_HOLD;
        end

        if (do_release)
        begin
            servo_next = cfg.finger_up_pulse;
            timer_next = rel_ticks;
            if (rel_ticks == '0)
            begin
                phase_next = kpms_pkg::PH_IDLE;
                done       = 1'b1;
            end
            else
            begin
                phase_next = kpms_pkg::PH_REL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= kpms_pkg::PH_IDLE;
            pos_reg    <= '0;
            target_reg <= '0;
            timer_reg  <= '0;
            held_reg   <= '0;
            servo_reg  <= kpms_pkg::FINGER_UP_PULSE_RST;
            dir_reg    <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            timer_reg  <= timer_next;
            held_reg   <= held_next;
            servo_reg  <= servo_next;
            dir_reg    <= dir_next;
        end
    end

    assign res_next.step_pin     = (phase_next == kpms_pkg::PH_HIGH);
    assign res_next.dir_pin      = dir_next;
    assign res_next.finger_pulse = servo_next;
    assign res_next.busy_res     = (phase_next != kpms_pkg::PH_IDLE);
    assign res_next.note_done    = done;
    assign res_next.rejected     = rej;
    assign res_next.position     = pos_next;

    assign status.phase    = phase_reg;
    assign status.position = pos_reg;

endmodule

// File: rtl/key_press_motion_sequencer_core.sv
// Top level of the key press motion sequencer: input register, engine, result register.
// Path: an accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while the sink takes results; each tick or note updates the state in one pass.
// A waiting result lets the input register take one more transaction, then stalls the input.
// Reset: asynchronous active-low rst_n clears both pipeline valids, the motion state
// (idle, position 0, finger up) and loads all configuration registers with their defaults.
module key_press_motion_sequencer_core #(
    parameter int NUM_KEYS   = kpms_pkg::NUM_KEYS_DEF,
    parameter int TIMER_BITS = kpms_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kpms_cmd_if.sink                        cmd,
    kpms_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [kpms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpms_pkg::CFG_DATA_W-1:0] cfg_data
);

    kpms_pkg::cfg_t    cfg;
    kpms_pkg::item_t   item_reg;
    kpms_pkg::result_t res_next;
    kpms_pkg::result_t out_reg;
    kpms_pkg::status_t status;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic adv;
    logic in_take;

    // Configuration registers; to be written only while the sequencer is idle, which the block does not enforce
    kpms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held transaction whenever the result register is free or being drained
    assign adv       = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || adv;
    assign in_take   = cmd.valid && cmd.ready;

    assign in_valid_next  = in_take || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming transaction payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind     <= cmd.kind;
            item_reg.note     <= cmd.note;
            item_reg.duration <= cmd.duration;
        end
    end

    // State update for one tick or note command
    kpms_engine #(
        .NUM_KEYS   (NUM_KEYS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item     (item_reg),
        .cfg      (cfg),
        .res_next (res_next),
        .status   (status)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.step_pin     = out_reg.step_pin;
    assign res.dir_pin      = out_reg.dir_pin;
    assign res.finger_pulse = out_reg.finger_pulse;
    assign res.busy_res     = out_reg.busy_res;
    assign res.note_done    = out_reg.note_done;
    assign res.rejected     = out_reg.rejected;
    assign res.position     = out_reg.position;

`ifndef NO_ASSERTIONS
    // An empty result register must never block the command side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cmd.ready)
        else $error("command side stalled with empty result register");

    // Only note commands can be rejected
    a_reject_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.rejected |-> item_reg.kind)
        else $error("tick transaction flagged as rejected");

    // A tick while idle never completes a note
    a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !item_reg.kind && (status.phase == kpms_pkg::PH_IDLE) |-> !res_next.note_done)
        else $error("note_done raised by a tick while idle");

    // The motor moves at most one count per processed transaction
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(adv) |-> (status.position == $past(status.position)) ||
                       (status.position == $past(status.position) + kpms_pkg::POS_W'(1)) ||
                       (status.position == $past(status.position) - kpms_pkg::POS_W'(1)))
        else $error("position jumped by more than one step");
`endif

endmodule

// File: tb/sv/key_press_motion_sequencer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the key press motion sequencer: directed script, then random traffic.
module key_press_motion_sequencer_core_tb;

    localparam int NUM_KEYS        = kpms_pkg::NUM_KEYS_DEF;
    localparam int TIMER_BITS      = kpms_pkg::TIMER_BITS_DEF;
    localparam int HALF_PERIOD     = 1;
    localparam int LIMIT_NS        = 2_000_000;
    localparam int ITEMS           = 950;
    localparam int SEG_ITEMS       = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int REPORT_MAX      = 10;
    localparam int MAX_ROWS        = 48;
    localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

    // A script row either programs one register or sends one transaction.
    typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [kpms_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [kpms_pkg::CFG_DATA_W-1:0] reg_value;
        kpms_pkg::item_t                 cmd;
        bit                              typed;
        kpms_pkg::result_t               want;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [kpms_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kpms_pkg::CFG_DATA_W-1:0] cfg_data;

    kpms_cmd_if cmd_ch ();
    kpms_res_if res_ch ();

    key_press_motion_sequencer_core #(
        .NUM_KEYS   (NUM_KEYS),
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Mirror of the arm: motion phase, stepper position, target, phase timer,
    // held duration, servo value, direction, plus the register settings.
    logic [kpms_pkg::PHASE_W-1:0] arm_phase;
    logic [kpms_pkg::POS_W-1:0]   arm_pos;
    logic [kpms_pkg::POS_W-1:0]   arm_goal;
    logic [63:0]                  arm_timer;
    logic [kpms_pkg::DUR_W-1:0]   arm_dur;
    logic [kpms_pkg::PULSE_W-1:0] arm_servo;
    logic                         arm_dir;
    kpms_pkg::cfg_t               arm_cfg;

    // Traffic shaping; the script sets the mix, the receiver owns its hold-off count.
    int src_idle_pct   = 21;
    int sink_stall_pct = 21;
    bit hold_off_armed = 1'b0;
    int hold_off_left  = HOLD_OFF_CYCLES;

    // Outputs still owed by the block, oldest first.
    kpms_pkg::result_t awaited_outputs[$];
    int                fail_count = 0;

    script_row_t plan [MAX_ROWS];
    int          plan_len = 0;

    // Zero half period counts as one tick.
    function automatic logic [63:0] step_half_ticks();
        return (arm_cfg.step_half_period == '0) ? 64'd1 : {48'd0, arm_cfg.step_half_period};
    endfunction

    // Lift the finger; a zero release time finishes the note right away.
    function automatic logic begin_release();
        arm_servo = arm_cfg.finger_up_pulse;
        arm_timer = {40'd0, arm_cfg.release_time} & TIMER_MAX;
        if (arm_timer == 64'd0)
        begin
            arm_phase = kpms_pkg::PH_IDLE;
            return 1'b1;
        end
        arm_phase = kpms_pkg::PH_REL;
        return 1'b0;
    endfunction

    // Press the key for duration times hold unit, saturated to the timer width.
    function automatic logic begin_press();
        logic [63:0] ticks;
        ticks = {56'd0, arm_dur} * {40'd0, arm_cfg.hold_unit};
        if (ticks > TIMER_MAX)
            ticks = TIMER_MAX;
        arm_servo = arm_cfg.finger_down_pulse;
        arm_timer = ticks;
        if (ticks == 64'd0)
            return begin_release();
        arm_phase = kpms_pkg::PH_HOLD;
        return 1'b0;
    endfunction

    // Take one step toward the target, or start the press once there.
    function automatic logic step_or_press();
        if (arm_pos == arm_goal)
            return begin_press();
        if (arm_goal > arm_pos)
        begin
            arm_dir = 1'b0;
            arm_pos = arm_pos + 1'b1;
        end
        else
        begin
            arm_dir = 1'b1;
            arm_pos = arm_pos - 1'b1;
        end
        arm_phase = kpms_pkg::PH_HIGH;
        arm_timer = step_half_ticks();
        return 1'b0;
    endfunction

    // Advance the mirror by one transaction and return the outputs it should show.
    function automatic kpms_pkg::result_t predict_motion(input kpms_pkg::item_t it);
        logic        done;
        logic        rej;
        int unsigned key;
        logic [31:0] spot;
        done = 1'b0;
        rej  = 1'b0;
        if (it.kind)
        begin
            if (arm_phase != kpms_pkg::PH_IDLE || it.note == '0 || it.note > NUM_KEYS)
            begin
                rej = 1'b1;
            end
            else
            begin
                key = it.note - 1;
                if (key == NUM_KEYS - 1)
                    spot = (NUM_KEYS - 2) * arm_cfg.key_spacing + arm_cfg.last_key_extra;
                else
                    spot = key * arm_cfg.key_spacing;
                arm_goal = spot[kpms_pkg::POS_W-1:0];
                arm_dur  = it.duration;
                done     = step_or_press();
            end
        end
        else if (arm_phase != kpms_pkg::PH_IDLE)
        begin
            if (arm_timer != 64'd0)
                arm_timer = arm_timer - 64'd1;
            if (arm_timer == 64'd0)
            begin
                case (arm_phase)
                    kpms_pkg::PH_HIGH:
                    begin
                        arm_phase = kpms_pkg::PH_LOW;
                        arm_timer = step_half_ticks();
                    end
                    kpms_pkg::PH_LOW:  done = step_or_press();
                    kpms_pkg::PH_HOLD: done = begin_release();
                    default:
                    begin
                        arm_phase = kpms_pkg::PH_IDLE;
                        done      = 1'b1;
                    end
                endcase
            end
        end
        return {(arm_phase == kpms_pkg::PH_HIGH), arm_dir, arm_servo,
                (arm_phase != kpms_pkg::PH_IDLE), done, rej, arm_pos};
    endfunction

    // Outputs of a block that has never moved: only the servo value and the pulses vary.
    function automatic kpms_pkg::result_t at_rest(input logic [kpms_pkg::PULSE_W-1:0] pulse,
                                                  input logic done, input logic rej);
        return {1'b0, 1'b0, pulse, 1'b0, done, rej, {kpms_pkg::POS_W{1'b0}}};
    endfunction

    function automatic void add_row_cmd(input logic kind,
                                        input logic [kpms_pkg::NOTE_W-1:0] note,
                                        input logic [kpms_pkg::DUR_W-1:0] dur,
                                        input bit typed, input kpms_pkg::result_t want);
        plan[plan_len].kind          = ROW_CMD;
        plan[plan_len].reg_index     = kpms_pkg::CFG_STEP_HALF_PERIOD;
        plan[plan_len].reg_value     = '0;
        plan[plan_len].cmd.kind      = kind;
        plan[plan_len].cmd.note      = note;
        plan[plan_len].cmd.duration  = dur;
        plan[plan_len].typed         = typed;
        plan[plan_len].want          = want;
        plan_len++;
    endfunction

    function automatic void add_row_reg(input logic [kpms_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [kpms_pkg::CFG_DATA_W-1:0] value);
        plan[plan_len].kind      = ROW_REG;
        plan[plan_len].reg_index = idx;
        plan[plan_len].reg_value = value;
        plan[plan_len].cmd       = '0;
        plan[plan_len].typed     = 1'b0;
        plan[plan_len].want      = '0;
        plan_len++;
    endfunction

    // Drop valid and let every owed output drain, then let the block settle.
    task automatic wait_for_quiet();
        cmd_ch.valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Program one register on a quiet block and track it in the mirror.
    task automatic write_reg(input logic [kpms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kpms_pkg::CFG_DATA_W-1:0] value);
        wait_for_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            kpms_pkg::CFG_STEP_HALF_PERIOD:
                arm_cfg.step_half_period = value[kpms_pkg::HALF_W-1:0];
            kpms_pkg::CFG_KEY_SPACING:
                arm_cfg.key_spacing = value[kpms_pkg::SPACE_W-1:0];
            kpms_pkg::CFG_LAST_KEY_EXTRA:
                arm_cfg.last_key_extra = value[kpms_pkg::SPACE_W-1:0];
            kpms_pkg::CFG_HOLD_UNIT:
                arm_cfg.hold_unit = value[kpms_pkg::TICKS_W-1:0];
            kpms_pkg::CFG_RELEASE_TIME:
                arm_cfg.release_time = value[kpms_pkg::TICKS_W-1:0];
            kpms_pkg::CFG_FINGER_DOWN_PULSE:
                arm_cfg.finger_down_pulse = value[kpms_pkg::PULSE_W-1:0];
            kpms_pkg::CFG_FINGER_UP_PULSE:
                arm_cfg.finger_up_pulse = value[kpms_pkg::PULSE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one transaction from a falling edge, optionally after an idle gap.
    // On acceptance, advance the mirror and queue what the block owes for it.
    task automatic send_cmd(input kpms_pkg::item_t it, input bit typed,
                            input kpms_pkg::result_t want, output kpms_pkg::result_t pred);
        int gap;
        if ($urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(4, 1);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.kind     <= it.kind;
        cmd_ch.note     <= it.note;
        cmd_ch.duration <= it.duration;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        pred = predict_motion(it);
        awaited_outputs.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Short settings keep whole notes brief; the servo values
    // span their full range.
    task automatic load_random_settings();
        write_reg(kpms_pkg::CFG_STEP_HALF_PERIOD, kpms_pkg::CFG_DATA_W'($urandom_range(2)));
        write_reg(kpms_pkg::CFG_KEY_SPACING, kpms_pkg::CFG_DATA_W'($urandom_range(3)));
        write_reg(kpms_pkg::CFG_LAST_KEY_EXTRA, kpms_pkg::CFG_DATA_W'($urandom_range(6)));
        write_reg(kpms_pkg::CFG_HOLD_UNIT, kpms_pkg::CFG_DATA_W'($urandom_range(3)));
        write_reg(kpms_pkg::CFG_RELEASE_TIME, kpms_pkg::CFG_DATA_W'($urandom_range(3)));
        write_reg(kpms_pkg::CFG_FINGER_DOWN_PULSE,
                  kpms_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
        write_reg(kpms_pkg::CFG_FINGER_UP_PULSE,
                  kpms_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
    endtask

    // Receiver: stall at random, or hold off for a counted stretch once armed.
    always @(negedge clk)
    begin
        if (hold_off_armed && hold_off_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare every accepted output, field by field, with the oldest owed one.
    always @(posedge clk)
    begin : check_outputs
        kpms_pkg::result_t got;
        kpms_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.step_pin, res_ch.dir_pin, res_ch.finger_pulse, res_ch.busy_res,
                   res_ch.note_done, res_ch.rejected, res_ch.position};
            if (awaited_outputs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                begin
                    $display("%0t: output with none owed: step %b dir %b pulse %0d",
                             $time, got.step_pin, got.dir_pin, got.finger_pulse);
                    $display("    busy %b done %b rej %b pos %0d",
                             got.busy_res, got.note_done, got.rejected, got.position);
                end
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (got.step_pin !== want.step_pin || got.dir_pin !== want.dir_pin ||
                    got.finger_pulse !== want.finger_pulse ||
                    got.busy_res !== want.busy_res || got.note_done !== want.note_done ||
                    got.rejected !== want.rejected || got.position !== want.position)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("%0t: mismatch (exp/got) step %b/%b dir %b/%b pulse %0d/%0d",
                                 $time, want.step_pin, got.step_pin, want.dir_pin,
                                 got.dir_pin, want.finger_pulse, got.finger_pulse);
                        $display("    busy %b/%b done %b/%b rej %b/%b pos %0d/%0d",
                                 want.busy_res, got.busy_res, want.note_done, got.note_done,
                                 want.rejected, got.rejected, want.position, got.position);
                    end
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        kpms_pkg::item_t   it;
        kpms_pkg::result_t pred;
        int                sent_items;
        int                seg;
        int                last_key;
        int                pick;
        int                hop;

        // Hold every input at a known value from time zero.
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = kpms_pkg::CFG_STEP_HALF_PERIOD;
        cfg_data        = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.kind     = 1'b0;
        cmd_ch.note     = '0;
        cmd_ch.duration = '0;

        // Mirror starts where reset leaves the block: idle at zero, finger up.
        arm_phase = kpms_pkg::PH_IDLE;
        arm_pos   = '0;
        arm_goal  = '0;
        arm_timer = 64'd0;
        arm_dur   = '0;
        arm_servo = kpms_pkg::FINGER_UP_PULSE_RST;
        arm_dir   = 1'b0;
        arm_cfg   = {kpms_pkg::STEP_HALF_PERIOD_RST, kpms_pkg::KEY_SPACING_RST,
                     kpms_pkg::LAST_KEY_EXTRA_RST, kpms_pkg::HOLD_UNIT_RST,
                     kpms_pkg::RELEASE_TIME_RST, kpms_pkg::FINGER_DOWN_PULSE_RST,
                     kpms_pkg::FINGER_UP_PULSE_RST};

        // Reset defaults: an idle tick shows the rest state, bad keys are rejected.
        add_row_cmd(1'b0, 5'd0, 8'd0, 1'b1, at_rest(kpms_pkg::FINGER_UP_PULSE_RST, 1'b0, 1'b0));
        add_row_cmd(1'b1, 5'd0, 8'd255, 1'b1,
                    at_rest(kpms_pkg::FINGER_UP_PULSE_RST, 1'b0, 1'b1));
        add_row_cmd(1'b1, 5'd26, 8'd1, 1'b1, at_rest(kpms_pkg::FINGER_UP_PULSE_RST, 1'b0, 1'b1));
        add_row_cmd(1'b1, 5'd31, 8'd0, 1'b1, at_rest(kpms_pkg::FINGER_UP_PULSE_RST, 1'b0, 1'b1));

        // Extreme settings. Key 1 is already under the finger, the hold is zero
        // (duration 0) and so is the release: the note finishes in its own cycle.
        add_row_reg(kpms_pkg::CFG_STEP_HALF_PERIOD, 24'd65535);
        add_row_reg(kpms_pkg::CFG_KEY_SPACING, 24'd1023);
        add_row_reg(kpms_pkg::CFG_LAST_KEY_EXTRA, 24'd1023);
        add_row_reg(kpms_pkg::CFG_HOLD_UNIT, 24'hFFFFFF);
        add_row_reg(kpms_pkg::CFG_RELEASE_TIME, 24'd0);
        add_row_reg(kpms_pkg::CFG_FINGER_DOWN_PULSE, 24'd65535);
        add_row_reg(kpms_pkg::CFG_FINGER_UP_PULSE, 24'd0);
        add_row_cmd(1'b1, 5'd1, 8'd0, 1'b1, at_rest(16'd0, 1'b1, 1'b0));
        add_row_cmd(1'b0, 5'd31, 8'd255, 1'b1, at_rest(16'd0, 1'b0, 1'b0));

        // Zero half period acts as one tick: two steps up, a busy command, a
        // one-tick hold and a one-tick release.
        add_row_reg(kpms_pkg::CFG_STEP_HALF_PERIOD, 24'd0);
        add_row_reg(kpms_pkg::CFG_KEY_SPACING, 24'd1);
        add_row_reg(kpms_pkg::CFG_LAST_KEY_EXTRA, 24'd0);
        add_row_reg(kpms_pkg::CFG_HOLD_UNIT, 24'd1);
        add_row_reg(kpms_pkg::CFG_RELEASE_TIME, 24'd1);
        add_row_reg(kpms_pkg::CFG_FINGER_DOWN_PULSE, 24'd0);
        add_row_reg(kpms_pkg::CFG_FINGER_UP_PULSE, 24'd65535);
        add_row_cmd(1'b1, 5'd3, 8'd1, 1'b0, '0);
        add_row_cmd(1'b1, 5'd5, 8'd9, 1'b0, '0);
        repeat (6) add_row_cmd(1'b0, 5'd31, 8'd255, 1'b0, '0);

        // Last key with zero spacing: one step down, then a zero hold that skips
        // straight to a two-tick release.
        add_row_reg(kpms_pkg::CFG_KEY_SPACING, 24'd0);
        add_row_reg(kpms_pkg::CFG_LAST_KEY_EXTRA, 24'd1);
        add_row_reg(kpms_pkg::CFG_HOLD_UNIT, 24'd0);
        add_row_reg(kpms_pkg::CFG_RELEASE_TIME, 24'd2);
        add_row_cmd(1'b1, 5'd25, 8'd200, 1'b0, '0);
        repeat (5) add_row_cmd(1'b0, 5'd0, 8'd0, 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < plan_len; i++)
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_index, plan[i].reg_value);
            else
                send_cmd(plan[i].cmd, plan[i].typed, plan[i].want, pred);
        end

        // Random traffic in segments, each with fresh settings and one of four
        // idling mixes. Mostly well-formed notes near the last key followed by the ticks
        // that play them; the rest is stray commands, bad keys and idle ticks.
        // Count every transaction sent.
        seg        = -1;
        sent_items = 0;
        last_key   = 1;
        while (sent_items < ITEMS)
        begin
            if (sent_items >= (seg + 1) * SEG_ITEMS)
            begin
                seg++;
                case (seg % 4)
                    0:
                    begin
                        src_idle_pct   = 0;
                        sink_stall_pct = 0;
                    end
                    1:
                    begin
                        src_idle_pct   = 57;
                        sink_stall_pct = 0;
                    end
                    2:
                    begin
                        src_idle_pct   = 0;
                        sink_stall_pct = 57;
                    end
                    default:
                    begin
                        src_idle_pct   = 21;
                        sink_stall_pct = 21;
                    end
                endcase
                load_random_settings();
                // Starve the output while the sender keeps pushing, so the
                // block fills up and has to stall its input.
                if (seg == 0)
                    hold_off_armed = 1'b1;
            end

            it.kind     = 1'b0;
            it.note     = kpms_pkg::NOTE_W'($urandom_range(31));
            it.duration = kpms_pkg::DUR_W'($urandom_range(255));
            pick        = $urandom_range(99);
            if (arm_phase == kpms_pkg::PH_IDLE)
            begin
                if (pick < 80)
                begin
                    it.kind = 1'b1;
                    if ($urandom_range(3) != 0)
                    begin
                        hop      = $urandom_range(6);
                        last_key = last_key + hop - 3;
                        if (last_key < 1)
                            last_key = 1;
                        if (last_key > NUM_KEYS)
                            last_key = NUM_KEYS;
                    end
                    else
                    begin
                        last_key = $urandom_range(NUM_KEYS, 1);
                    end
                    it.note = kpms_pkg::NOTE_W'(last_key);
                    // Keep most holds short; now and then take any duration.
                    if ($urandom_range(15) != 0)
                        it.duration = kpms_pkg::DUR_W'($urandom_range(3));
                end
                else if (pick >= 90)
                begin
                    it.kind = 1'b1;
                end
            end
            else if (pick >= 92)
            begin
                it.kind = 1'b1;
            end

            send_cmd(it, 1'b0, '0, pred);
            sent_items++;
        end

        // Drain what is still owed, give the pipeline time to show any stray
        // output, then report.
        cmd_ch.valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
